// File: rtl/mbe_pkg.sv
// Shared register map constants for the escape-time block.
`timescale 1ns / 1ps
`default_nettype none
package mbe_pkg;

	typedef logic [1:0] reg_idx_t;

	localparam reg_idx_t REG_MAX_ITER = 2'd0;
	localparam reg_idx_t REG_START_RE = 2'd1;
	localparam reg_idx_t REG_START_IM = 2'd2;

	localparam logic [15:0] MAX_ITER_RESET = 16'd1000;

	localparam int QUEUE_DEPTH = 4;

endpackage
`default_nettype wire

// File: rtl/mbe_if.sv
// Valid/ready channel interfaces for points and escape counts.
`timescale 1ns / 1ps
`default_nettype none
interface mbe_point_if #(
	parameter int DATA_WIDTH = 32
);
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] point_re;
	logic signed [DATA_WIDTH-1:0] point_im;

	modport source (output valid, output point_re, output point_im, input ready);
	modport sink (input valid, input point_re, input point_im, output ready);
endinterface

interface mbe_count_if #(
	parameter int COUNT_WIDTH = 16
);
	logic                   valid;
	logic                   ready;
	logic [COUNT_WIDTH-1:0] escape_count;

	modport source (output valid, output escape_count, input ready);
	modport sink (input valid, input escape_count, output ready);
endinterface
`default_nettype wire

// File: rtl/mbe_regs.sv
// APB configuration registers: iteration limit and start value.
`timescale 1ns / 1ps
`default_nettype none
module mbe_regs
	import mbe_pkg::*;
#(
	parameter int DATA_WIDTH  = 32,
	parameter int COUNT_WIDTH = 16,
	parameter int PDW         = 32,
	parameter int PAW         = 4
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [PAW-1:0]               paddr,
	input  wire logic [PDW-1:0]               pwdata,
	output logic      [PDW-1:0]               prdata,
	output logic                              pready,
	output logic      [COUNT_WIDTH-1:0]       max_iter,
	output logic signed [DATA_WIDTH-1:0]      start_re,
	output logic signed [DATA_WIDTH-1:0]      start_im
);

	reg_idx_t                     idx;
	logic                         wr_en;
	logic [COUNT_WIDTH-1:0]       max_iter_q;
	logic signed [DATA_WIDTH-1:0] start_re_q;
	logic signed [DATA_WIDTH-1:0] start_im_q;

	assign idx    = paddr[PAW-1:PAW-2];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_iter_q <= COUNT_WIDTH'(MAX_ITER_RESET);
			start_re_q <= '0;
			start_im_q <= '0;
		end else if (wr_en) begin
			unique case (idx)
				REG_MAX_ITER: max_iter_q <= COUNT_WIDTH'(pwdata[15:0]);
				REG_START_RE: start_re_q <= pwdata[DATA_WIDTH-1:0];
				REG_START_IM: start_im_q <= pwdata[DATA_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_MAX_ITER: prdata = PDW'(max_iter_q);
			REG_START_RE: prdata = PDW'(unsigned'(start_re_q));
			REG_START_IM: prdata = PDW'(unsigned'(start_im_q));
			default:      prdata = '0;
		endcase
	end

	assign max_iter = max_iter_q;
	assign start_re = start_re_q;
	assign start_im = start_im_q;

endmodule
`default_nettype wire

// File: rtl/mbe_front.sv
// Front end: accepts points and holds them in a short queue for the core.
`timescale 1ns / 1ps
`default_nettype none
module mbe_front
	import mbe_pkg::*;
#(
	parameter int DATA_WIDTH = 32
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	mbe_point_if.sink                    point,
	output logic                         q_valid,
	input  wire logic                    q_pop,
	output logic signed [DATA_WIDTH-1:0] q_re,
	output logic signed [DATA_WIDTH-1:0] q_im
);

	localparam int PW = $clog2(QUEUE_DEPTH);

	logic signed [DATA_WIDTH-1:0] re_q [QUEUE_DEPTH];
	logic signed [DATA_WIDTH-1:0] im_q [QUEUE_DEPTH];
	logic [PW-1:0]                wr_ptr_q;
	logic [PW-1:0]                rd_ptr_q;
	logic [PW:0]                  fill_q;
	logic                         push;
	logic                         pop;

	assign point.ready = (fill_q != (PW+1)'(QUEUE_DEPTH));
	assign push        = point.valid && point.ready;
	assign q_valid     = (fill_q != '0);
	assign pop         = q_pop && q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			re_q[wr_ptr_q] <= point.point_re;
			im_q[wr_ptr_q] <= point.point_im;
		end
	end

	assign q_re = re_q[rd_ptr_q];
	assign q_im = im_q[rd_ptr_q];

endmodule
`default_nettype wire

// File: rtl/mbe_core.sv
// Back end: iterates z = z^2 + c, one SQ state and one TEST state per iteration, and holds the count.
`timescale 1ns / 1ps
`default_nettype none
module mbe_core #(
	parameter int DATA_WIDTH  = 32,
	parameter int FRAC_BITS   = 28,
	parameter int COUNT_WIDTH = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [COUNT_WIDTH-1:0]        max_iter,
	input  wire logic signed [DATA_WIDTH-1:0]  start_re,
	input  wire logic signed [DATA_WIDTH-1:0]  start_im,
	input  wire logic                          q_valid,
	output logic                               q_pop,
	input  wire logic signed [DATA_WIDTH-1:0]  q_re,
	input  wire logic signed [DATA_WIDTH-1:0]  q_im,
	mbe_count_if.source                        result
);

	localparam int DW  = DATA_WIDTH;
	localparam int SQW = FRAC_BITS + 4;
	localparam int XW  = (2 * DW > SQW) ? 2 * DW : SQW;
	localparam int WW  = ((DW > SQW) ? DW : SQW) + 1;

	localparam logic [SQW-1:0] SQ_CAP  = SQW'(8) << FRAC_BITS;
	localparam logic [SQW:0]   FOUR_FX = (SQW+1)'(4) << FRAC_BITS;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SQ   = 2'd1;
	localparam logic [1:0] ST_TEST = 2'd2;

	// floor(v*v / 2^FRAC_BITS), saturated at 8.0
	function automatic logic [SQW-1:0] fx_square(input logic [DW-1:0] v);
		logic [DW-1:0]   m;
		logic [2*DW-1:0] p;
		logic [XW-1:0]   s;
		m = v[DW-1] ? (~v + 1'b1) : v;
		p = {{DW{1'b0}}, m} * {{DW{1'b0}}, m};
		s = XW'(p) >> FRAC_BITS;
		if (s > XW'(SQ_CAP)) begin
			return SQ_CAP;
		end
		return s[SQW-1:0];
	endfunction

	logic [1:0]                   state_q;
	logic signed [DW-1:0]         z_re_q;
	logic signed [DW-1:0]         z_im_q;
	logic signed [DW-1:0]         c_re_q;
	logic signed [DW-1:0]         c_im_q;
	logic [COUNT_WIDTH-1:0]       iter_q;
	logic [SQW-1:0]               sq_re_q;
	logic [SQW-1:0]               sq_im_q;
	logic [DW-1:0]                tp_q;
	logic                         out_valid_q;
	logic [COUNT_WIDTH-1:0]       out_count_q;
	logic signed [2*DW-1:0]       prod;
	logic signed [2*DW-1:0]       prod_sh;
	logic [SQW:0]                 mag_sum;
	logic                         escaped;
	logic                         last;
	logic                         out_free;
	logic                         out_load;
	logic [WW-1:0]                re_next;
	logic [DW-1:0]                im_next;

	assign prod    = z_im_q * z_re_q;
	assign prod_sh = prod >>> (FRAC_BITS - 1);
	assign mag_sum = (SQW+1)'(sq_re_q) + (SQW+1)'(sq_im_q);
	assign escaped = (mag_sum > FOUR_FX);
	assign last    = (({1'b0, iter_q} + 1'b1) >= {1'b0, max_iter});
	assign out_free = !out_valid_q || result.ready;
	assign out_load = (state_q == ST_TEST) && (escaped || last) && out_free;
	assign re_next = WW'(sq_re_q) - WW'(sq_im_q)
		+ {{(WW-DW){c_re_q[DW-1]}}, c_re_q};
	assign im_next = tp_q + c_im_q;

	assign q_pop = (state_q == ST_IDLE) && q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						state_q <= ST_SQ;
					end
				end
				ST_SQ: begin
					state_q <= ST_TEST;
				end
				ST_TEST: begin
					if (!(escaped || last)) begin
						state_q <= ST_SQ;
					end else if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				z_re_q <= start_re;
				z_im_q <= start_im;
				c_re_q <= q_re;
				c_im_q <= q_im;
				iter_q <= '0;
			end
			ST_SQ: begin
				sq_re_q <= fx_square(z_re_q);
				sq_im_q <= fx_square(z_im_q);
				tp_q    <= prod_sh[DW-1:0];
			end
			ST_TEST: begin
				if (!(escaped || last)) begin
					z_re_q <= re_next[DW-1:0];
					z_im_q <= im_next;
					iter_q <= iter_q + 1'b1;
				end else if (out_free) begin
					out_count_q <= escaped ? iter_q : max_iter;
				end
			end
			default: ;
		endcase
	end

	assign result.valid        = out_valid_q;
	assign result.escape_count = out_count_q;

endmodule
`default_nettype wire

// File: rtl/mandelbrot_escape_time_top.sv
// Top level of the Mandelbrot escape-time counter.
// A point leaves the queue in IDLE; the core then alternates SQ (multiply) and TEST
// (add and escape test) until the point escapes or reaches max_iter.
// One point at a time in the core; a four-entry queue keeps taking points meanwhile.
// arst_n clears the queue, the core state and the result valid; registers return
// to max_iter = 1000 and a zero start value.
`timescale 1ns / 1ps
`default_nettype none
module mandelbrot_escape_time_top
	import mbe_pkg::*;
#(
	parameter int DATA_WIDTH  = 32,
	parameter int FRAC_BITS   = 28,
	parameter int COUNT_WIDTH = 16,
	localparam int PDW        = (DATA_WIDTH > 32) ? 64 : 32,
	localparam int PAW        = (DATA_WIDTH > 32) ? 5 : 4
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           psel,
	input  wire logic           penable,
	input  wire logic           pwrite,
	input  wire logic [PAW-1:0] paddr,
	input  wire logic [PDW-1:0] pwdata,
	output logic      [PDW-1:0] prdata,
	output logic                pready,
	mbe_point_if.sink           point,
	mbe_count_if.source         result
);

	logic [COUNT_WIDTH-1:0]       max_iter;
	logic signed [DATA_WIDTH-1:0] start_re;
	logic signed [DATA_WIDTH-1:0] start_im;
	logic                         q_valid;
	logic                         q_pop;
	logic signed [DATA_WIDTH-1:0] q_re;
	logic signed [DATA_WIDTH-1:0] q_im;

	mbe_regs #(
		.DATA_WIDTH  (DATA_WIDTH),
		.COUNT_WIDTH (COUNT_WIDTH),
		.PDW         (PDW),
		.PAW         (PAW)
	) u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.max_iter (max_iter),
		.start_re (start_re),
		.start_im (start_im)
	);

	mbe_front #(
		.DATA_WIDTH (DATA_WIDTH)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.point   (point),
		.q_valid (q_valid),
		.q_pop   (q_pop),
		.q_re    (q_re),
		.q_im    (q_im)
	);

	mbe_core #(
		.DATA_WIDTH  (DATA_WIDTH),
		.FRAC_BITS   (FRAC_BITS),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.max_iter (max_iter),
		.start_re (start_re),
		.start_im (start_im),
		.q_valid  (q_valid),
		.q_pop    (q_pop),
		.q_re     (q_re),
		.q_im     (q_im),
		.result   (result)
	);

	a_pop_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("core popped an empty queue");

	a_no_double_pop: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> !q_pop)
		else $error("core popped twice in a row");

	a_push_visible: assert property (@(posedge clk) disable iff (!arst_n)
		(point.valid && point.ready) |=> q_valid)
		else $error("accepted item not visible in queue");

endmodule
`default_nettype wire

// File: bench/tb_mandelbrot_escape_time_top.sv
// Testbench for the escape-time block: APB setup, random points and stalls, counts predicted in SV.
`timescale 1ns / 1ps
module tb_mandelbrot_escape_time_top
	import mbe_pkg::*;
();

	localparam int DW = 32;
	localparam int FB = 28;
	localparam int CW = 16;
	localparam int RUN_LIMIT = 3000000;
	localparam int HOLD_CYCLES = 3000;

	localparam logic [63:0] FOUR_FX = 64'd4 << FB;
	localparam logic [63:0] SQ_CAP = 64'd8 << FB;

	localparam logic [DW-1:0] FX_ZERO = 32'h0000_0000;
	localparam logic [DW-1:0] FX_ONE = 32'h1000_0000;
	localparam logic [DW-1:0] FX_TWO = 32'h2000_0000;
	localparam logic [DW-1:0] FX_THREE = 32'h3000_0000;
	localparam logic [DW-1:0] FX_QUARTER = 32'h0400_0000;
	localparam logic [DW-1:0] FX_NEG_TWO = 32'hE000_0000;
	localparam logic [DW-1:0] FX_MAX = 32'h7FFF_FFFF;
	localparam logic [DW-1:0] FX_MIN = 32'h8000_0000;

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [3:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	mbe_point_if #(.DATA_WIDTH(DW)) point_ch ();
	mbe_count_if #(.COUNT_WIDTH(CW)) count_ch ();

	mandelbrot_escape_time_top u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.point(point_ch),
		.result(count_ch)
	);

	logic [CW-1:0] cfg_max_iter;
	logic [DW-1:0] cfg_start_re;
	logic [DW-1:0] cfg_start_im;

	logic [CW-1:0] pending_counts[$];
	int mismatch_count = 0;
	int cycle_count = 0;
	bit src_idle = 1'b1;
	bit sink_idle = 1'b1;
	int sink_hold = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= RUN_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic report_mismatch(string msg);
		if (mismatch_count < 50)
			$display("[%0t] mismatch: %s", $realtime, msg);
		mismatch_count++;
	endtask

	// floor(v*v / 2^FB), saturated at 8.0
	function automatic logic [63:0] sat_square(logic [DW-1:0] v);
		logic [DW-1:0] mag;
		logic [127:0] prod;
		logic [127:0] q;
		mag = v[DW-1] ? -v : v;
		prod = 128'(mag) * 128'(mag);
		q = prod >> FB;
		return (q > 128'(SQ_CAP)) ? SQ_CAP : q[63:0];
	endfunction

	// floor(2*a*b / 2^FB), wrapped
	function automatic logic [DW-1:0] twice_product(logic [DW-1:0] a, logic [DW-1:0] b);
		logic [DW-1:0] ma;
		logic [DW-1:0] mb;
		logic [127:0] prod;
		logic [127:0] q;
		ma = a[DW-1] ? -a : a;
		mb = b[DW-1] ? -b : b;
		prod = 128'(ma) * 128'(mb);
		q = prod >> (FB - 1);
		if (a[DW-1] ^ b[DW-1])
			q = -q - 128'(|prod[FB-2:0]);
		return q[DW-1:0];
	endfunction

	function automatic logic [CW-1:0] escape_count_of(logic [DW-1:0] c_re, logic [DW-1:0] c_im);
		logic [DW-1:0] z_re;
		logic [DW-1:0] z_im;
		logic [63:0] sq_re;
		logic [63:0] sq_im;
		int unsigned i;
		z_re = cfg_start_re;
		z_im = cfg_start_im;
		sq_re = sat_square(z_re);
		sq_im = sat_square(z_im);
		if (sq_re + sq_im > FOUR_FX)
			return '0;
		for (i = 1; i < cfg_max_iter; i++) begin
			z_im = twice_product(z_im, z_re) + c_im;
			z_re = sq_re[DW-1:0] - sq_im[DW-1:0] + c_re;
			sq_re = sat_square(z_re);
			sq_im = sat_square(z_im);
			if (sq_re + sq_im > FOUR_FX)
				return CW'(i);
		end
		return cfg_max_iter;
	endfunction

	function automatic logic [31:0] reg_value(reg_idx_t idx);
		case (idx)
			REG_MAX_ITER: return 32'(cfg_max_iter);
			REG_START_RE: return cfg_start_re;
			REG_START_IM: return cfg_start_im;
			default: return '0;
		endcase
	endfunction

	always @(posedge clk) begin : count_check
		logic [CW-1:0] want;
		if (arst_n && count_ch.valid && count_ch.ready) begin
			if (pending_counts.size() == 0) begin
				report_mismatch($sformatf("escape_count %0d with no point pending",
					count_ch.escape_count));
			end else begin
				want = pending_counts.pop_front();
				if (count_ch.escape_count !== want)
					report_mismatch($sformatf("escape_count got %0d want %0d",
						count_ch.escape_count, want));
			end
		end
	end

	initial begin : count_sink
		int stall;
		count_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = sink_idle ? $urandom_range(0, 4) : 0;
			if (sink_hold > 0) begin
				stall = sink_hold;
				sink_hold = 0;
			end
			if (stall > 0) begin
				@(negedge clk);
				count_ch.ready <= 1'b0;
				repeat (stall - 1) @(negedge clk);
			end
			@(negedge clk);
			count_ch.ready <= 1'b1;
			do @(posedge clk); while (!count_ch.valid);
		end
	end

	task automatic send_point(logic [DW-1:0] c_re, logic [DW-1:0] c_im);
		int gap;
		gap = src_idle ? $urandom_range(0, 4) : 0;
		if (gap > 0) begin
			@(negedge clk);
			point_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		point_ch.valid <= 1'b1;
		point_ch.point_re <= c_re;
		point_ch.point_im <= c_im;
		do @(posedge clk); while (!point_ch.ready);
		pending_counts.push_back(escape_count_of(c_re, c_im));
	endtask

	task automatic send_random_point();
		logic [DW-1:0] c_re;
		logic [DW-1:0] c_im;
		if ($urandom_range(0, 9) < 2) begin
			c_re = $urandom;
			c_im = $urandom;
		end else begin
			c_re = $urandom_range(0, 32'h4000_0000) - 32'h2800_0000;
			c_im = $urandom_range(0, 32'h2800_0000) - 32'h1400_0000;
		end
		send_point(c_re, c_im);
	endtask

	task automatic wait_idle();
		@(negedge clk);
		point_ch.valid <= 1'b0;
		while (pending_counts.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic read_reg(reg_idx_t idx, output logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b0;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		value = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic check_reg(reg_idx_t idx);
		logic [31:0] value;
		read_reg(idx, value);
		if (value !== reg_value(idx))
			report_mismatch($sformatf("register %0d reads %h want %h", idx, value,
				reg_value(idx)));
	endtask

	task automatic write_reg(reg_idx_t idx, logic [31:0] value);
		wait_idle();
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_MAX_ITER: cfg_max_iter = value[CW-1:0];
			REG_START_RE: cfg_start_re = value;
			REG_START_IM: cfg_start_im = value;
			default: ;
		endcase
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		check_reg(idx);
	endtask

	task automatic test_register_reset();
		check_reg(REG_MAX_ITER);
		check_reg(REG_START_RE);
		check_reg(REG_START_IM);
	endtask

	task automatic test_default_points();
		send_point(FX_ZERO, FX_ZERO);
		send_point(FX_NEG_TWO, FX_ZERO);
		send_point(FX_QUARTER, FX_ZERO);
		send_point(FX_ONE, FX_ZERO);
		send_point(FX_ZERO, FX_ONE);
		send_point(FX_ONE, FX_ONE);
		send_point(FX_MAX, FX_MAX);
		send_point(FX_MIN, FX_MIN);
		send_point(FX_MAX, FX_MIN);
		send_point(FX_MIN, FX_MAX);
	endtask

	// no iteration at all: count 0 whether z0 escapes or not
	task automatic test_zero_limit();
		write_reg(REG_MAX_ITER, 32'd0);
		send_point(FX_ZERO, FX_ZERO);
		send_point(FX_THREE, FX_THREE);
		write_reg(REG_START_RE, FX_MIN);
		send_point(FX_ZERO, FX_ZERO);
	endtask

	task automatic test_large_start();
		write_reg(REG_MAX_ITER, 32'd50);
		write_reg(REG_START_IM, FX_MAX);
		send_point(FX_ZERO, FX_ZERO);
		write_reg(REG_START_RE, FX_TWO);
		write_reg(REG_START_IM, FX_ZERO);
		send_point(FX_ZERO, FX_ZERO);
		write_reg(REG_START_RE, FX_TWO - 1);
		send_point(FX_NEG_TWO, FX_ZERO);
		write_reg(REG_START_RE, FX_ZERO);
	endtask

	task automatic test_limit_extremes();
		write_reg(REG_MAX_ITER, 32'd1);
		send_point(FX_ZERO, FX_ZERO);
		send_point(FX_THREE, FX_ZERO);
		write_reg(REG_MAX_ITER, 32'd65535);
		send_point(FX_ONE, FX_ONE);
		send_point(FX_ZERO, FX_ZERO);
	endtask

	task automatic test_random_phases();
		int unsigned limit;
		for (int p = 0; p < 6; p++) begin
			case (p)
				0: limit = 2;
				1: limit = $urandom_range(3, 32);
				2: limit = 64;
				3: limit = 255;
				4: limit = $urandom_range(100, 200);
				default: limit = $urandom_range(1, 16);
			endcase
			write_reg(REG_MAX_ITER, limit);
			if (p == 5) begin
				write_reg(REG_START_RE, $urandom);
				write_reg(REG_START_IM, $urandom);
			end else if (p % 2 == 1) begin
				write_reg(REG_START_RE, $urandom_range(0, 32'h1000_0000) - 32'h0800_0000);
				write_reg(REG_START_IM, $urandom_range(0, 32'h1000_0000) - 32'h0800_0000);
			end else begin
				write_reg(REG_START_RE, FX_ZERO);
				write_reg(REG_START_IM, FX_ZERO);
			end
			src_idle = (p != 2);
			sink_idle = (p != 3);
			repeat (100) send_random_point();
		end
		src_idle = 1'b1;
		sink_idle = 1'b1;
	endtask

	// sink stops for a long stretch while points keep coming
	task automatic test_backpressure();
		write_reg(REG_MAX_ITER, 32'd8);
		write_reg(REG_START_RE, FX_ZERO);
		write_reg(REG_START_IM, FX_ZERO);
		src_idle = 1'b0;
		sink_hold = HOLD_CYCLES;
		repeat (16) send_random_point();
		src_idle = 1'b1;
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		point_ch.valid = 1'b0;
		point_ch.point_re = '0;
		point_ch.point_im = '0;
		cfg_max_iter = MAX_ITER_RESET;
		cfg_start_re = '0;
		cfg_start_im = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_register_reset();
		test_default_points();
		test_zero_limit();
		test_large_start();
		test_limit_extremes();
		test_random_phases();
		test_backpressure();

		wait_idle();
		repeat (2 * cfg_max_iter + 10) @(posedge clk);
		if (mismatch_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
